### design/ipsvm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipsvm_pkg: shared types and constants for the inverse Park / SVM timing block
// Holds the fixed field widths, the fixed-point constants of the rotation and
// modulation path, and the sextant codes.
// ----------------------------------------------------------------------------
package ipsvm_pkg;

    localparam int VOLT_W       = 16;
    localparam int TAB_W        = 16;
    localparam int PROD_W       = 32;
    localparam int ROT_W        = 33;
    localparam int COEF_W       = 21;
    localparam int Q50_W        = 58;
    localparam int DUTY_W       = 17;
    localparam int DUTY_SHIFT   = 35;
    localparam int TAYLOR_TERMS = 12;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [COEF_W-1:0] INV_SQRT3_Q20     = 21'd605396;
    localparam logic [COEF_W-1:0] TWO_INV_SQRT3_Q20 = 21'd1210791;

    localparam logic signed [Q50_W-1:0] Q50_ONE    = 58'sd1125899906842624;
    localparam logic signed [Q50_W-1:0] Q50_TWO    = 58'sd2251799813685248;
    localparam logic signed [Q50_W-1:0] ROUND_HALF = 58'sd17179869184;

    typedef enum logic [2:0] {
        SECTOR_V1V2 = 3'd0,
        SECTOR_V2V3 = 3'd1,
        SECTOR_V3V4 = 3'd2,
        SECTOR_V4V5 = 3'd3,
        SECTOR_V5V6 = 3'd4,
        SECTOR_V6V1 = 3'd5
    } sector_t;

endpackage
`default_nettype wire

### design/inverse_park_svm_timing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inverse_park_svm_timing: inverse Park rotation and space-vector timing
// Rotates a (d, q) voltage command into alpha-beta with a quarter-wave sine
// table, finds the sextant and produces saturated phase timings.
//
//   Channel  Direction  Handshake            Payload
//   in       sink       in_valid / in_stall  volt_d, volt_q, rotor_angle
//   out      source     out_valid/out_stall  duty_a, duty_b, duty_c,
//                                            sector, in_range
//
// The pipeline has nine stages and takes one transfer per clock while
// in_stall is low. The registered table read and the Q50 multiply stage set
// the stage split. Reset clears only the stage valid bits. A stall on the
// output holds the last stage while the earlier stages keep closing up empty
// slots; in_stall rises only when every stage holds an item.
// ----------------------------------------------------------------------------
module inverse_park_svm_timing #(
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [ipsvm_pkg::VOLT_W-1:0]    volt_d,
    input  logic signed [ipsvm_pkg::VOLT_W-1:0]    volt_q,
    input  logic [ANGLE_BITS-1:0]                  rotor_angle,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [ipsvm_pkg::DUTY_W-1:0]           duty_a,
    output logic [ipsvm_pkg::DUTY_W-1:0]           duty_b,
    output logic [ipsvm_pkg::DUTY_W-1:0]           duty_c,
    output logic [2:0]                             sector,
    output logic                                   in_range
);

    localparam int ADDR_W     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int REST_W     = ANGLE_BITS - 2;
    localparam int IDX_PROD_W = REST_W + ADDR_W;
    localparam int KPROD_W    = ipsvm_pkg::ROT_W + ipsvm_pkg::COEF_W + 1;
    localparam int STAGES     = 9;
    localparam int QW         = ipsvm_pkg::Q50_W;

    function automatic logic [ipsvm_pkg::DUTY_W-1:0] to_duty(
        input logic signed [QW-1:0] t
    );
        logic signed [QW-1:0] c;
        logic [QW-1:0]        r;
        if (t < 0)
        begin
            c = '0;
        end
        else if (t > ipsvm_pkg::Q50_TWO)
        begin
            c = ipsvm_pkg::Q50_TWO;
        end
        else
        begin
            c = t;
        end
        r = $unsigned(c) + $unsigned(ipsvm_pkg::ROUND_HALF);
        return r[ipsvm_pkg::DUTY_SHIFT +: ipsvm_pkg::DUTY_W];
    endfunction

    function automatic logic within_unit(input logic signed [QW-1:0] t);
        return !t[QW-1] && !(t > ipsvm_pkg::Q50_TWO);
    endfunction

    logic [STAGES:1] valid_reg;
    logic [STAGES:1] valid_next;
    logic [STAGES:1] adv;

    always_comb
    begin
        adv[STAGES] = !valid_reg[STAGES] || !out_stall;
        for (int i = STAGES - 1; i >= 1; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (adv[1])
        begin
            valid_next[1] = in_valid;
        end
        for (int i = 2; i <= STAGES; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_stall  = !adv[1];
    assign out_valid = valid_reg[STAGES];

    // Stage 1: table indices.
    logic [REST_W-1:0]     rest_w;
    logic [IDX_PROD_W-1:0] idx_prod_w;
    logic [ADDR_W-1:0]     idx_w;
    logic [ADDR_W-1:0]     cidx_w;

    assign rest_w     = rotor_angle[REST_W-1:0];
    assign idx_prod_w = IDX_PROD_W'(rest_w) * IDX_PROD_W'(SINE_TABLE_DEPTH);
    assign idx_w      = idx_prod_w[IDX_PROD_W-1:REST_W];
    assign cidx_w     = ADDR_W'(SINE_TABLE_DEPTH) - idx_w;

    logic signed [ipsvm_pkg::VOLT_W-1:0] s1_d_reg;
    logic signed [ipsvm_pkg::VOLT_W-1:0] s1_q_reg;
    logic [1:0]                          s1_quad_reg;
    logic [ADDR_W-1:0]                   s1_idx_reg;
    logic [ADDR_W-1:0]                   s1_cidx_reg;

    // Stage 2: table read.
    logic signed [ipsvm_pkg::VOLT_W-1:0] s2_d_reg;
    logic signed [ipsvm_pkg::VOLT_W-1:0] s2_q_reg;
    logic [1:0]                          s2_quad_reg;
    logic [ipsvm_pkg::TAB_W-1:0]         tab_idx;
    logic [ipsvm_pkg::TAB_W-1:0]         tab_cidx;

    ipsvm_sine_rom #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_sine_rom (
        .clk    (clk),
        .rd_en  (adv[2]),
        .addr_a (s1_idx_reg),
        .addr_b (s1_cidx_reg),
        .data_a (tab_idx),
        .data_b (tab_cidx)
    );

    // Stage 3: products of the command with the table magnitudes.
    logic [ipsvm_pkg::TAB_W-1:0]       mag_s;
    logic [ipsvm_pkg::TAB_W-1:0]       mag_c;
    logic signed [ipsvm_pkg::PROD_W:0] dc_full;
    logic signed [ipsvm_pkg::PROD_W:0] qs_full;
    logic signed [ipsvm_pkg::PROD_W:0] ds_full;
    logic signed [ipsvm_pkg::PROD_W:0] qc_full;

    assign mag_s   = s2_quad_reg[0] ? tab_cidx : tab_idx;
    assign mag_c   = s2_quad_reg[0] ? tab_idx : tab_cidx;
    assign dc_full = s2_d_reg * $signed({1'b0, mag_c});
    assign qs_full = s2_q_reg * $signed({1'b0, mag_s});
    assign ds_full = s2_d_reg * $signed({1'b0, mag_s});
    assign qc_full = s2_q_reg * $signed({1'b0, mag_c});

    logic signed [ipsvm_pkg::PROD_W-1:0] s3_dc_reg;
    logic signed [ipsvm_pkg::PROD_W-1:0] s3_qs_reg;
    logic signed [ipsvm_pkg::PROD_W-1:0] s3_ds_reg;
    logic signed [ipsvm_pkg::PROD_W-1:0] s3_qc_reg;
    logic                                s3_neg_s_reg;
    logic                                s3_neg_c_reg;

    // Stage 4: alpha and beta in Q30.
    logic signed [ipsvm_pkg::ROT_W-1:0] dc_w;
    logic signed [ipsvm_pkg::ROT_W-1:0] qs_w;
    logic signed [ipsvm_pkg::ROT_W-1:0] ds_w;
    logic signed [ipsvm_pkg::ROT_W-1:0] qc_w;
    logic signed [ipsvm_pkg::ROT_W-1:0] al_next;
    logic signed [ipsvm_pkg::ROT_W-1:0] be_next;

    assign dc_w    = ipsvm_pkg::ROT_W'(s3_dc_reg);
    assign qs_w    = ipsvm_pkg::ROT_W'(s3_qs_reg);
    assign ds_w    = ipsvm_pkg::ROT_W'(s3_ds_reg);
    assign qc_w    = ipsvm_pkg::ROT_W'(s3_qc_reg);
    assign al_next = (s3_neg_c_reg ? -dc_w : dc_w) - (s3_neg_s_reg ? -qs_w : qs_w);
    assign be_next = (s3_neg_s_reg ? -ds_w : ds_w) + (s3_neg_c_reg ? -qc_w : qc_w);

    logic signed [ipsvm_pkg::ROT_W-1:0] s4_al_reg;
    logic signed [ipsvm_pkg::ROT_W-1:0] s4_be_reg;

    // Stage 5: scaling into Q50.
    logic signed [KPROD_W-1:0] kb_full;
    logic signed [KPROD_W-1:0] y0_full;
    logic signed [QW-1:0]      al50_w;

    assign kb_full = s4_be_reg * $signed({1'b0, ipsvm_pkg::INV_SQRT3_Q20});
    assign y0_full = s4_be_reg * $signed({1'b0, ipsvm_pkg::TWO_INV_SQRT3_Q20});
    assign al50_w  = QW'(s4_al_reg) <<< 20;

    logic signed [QW-1:0] s5_al_reg;
    logic signed [QW-1:0] s5_kb_reg;
    logic signed [QW-1:0] s5_y0_reg;

    // Stage 6: the two sextant comparisons as sum and difference.
    logic signed [QW-1:0] s6_diff_reg;
    logic signed [QW-1:0] s6_sum_reg;
    logic signed [QW-1:0] s6_y0_reg;
    logic                 s6_al_neg_reg;
    logic                 s6_be_neg_reg;

    // Stage 7: sextant and the two on-times.
    ipsvm_pkg::sector_t   sec_w;
    logic signed [QW-1:0] x_w;
    logic signed [QW-1:0] y_w;

    always_comb
    begin
        if (!s6_be_neg_reg)
        begin
            if (!s6_al_neg_reg)
            begin
                sec_w = s6_diff_reg[QW-1] ? ipsvm_pkg::SECTOR_V2V3 : ipsvm_pkg::SECTOR_V1V2;
            end
            else
            begin
                sec_w = s6_sum_reg[QW-1] ? ipsvm_pkg::SECTOR_V3V4 : ipsvm_pkg::SECTOR_V2V3;
            end
        end
        else
        begin
            if (!s6_al_neg_reg)
            begin
                sec_w = s6_sum_reg[QW-1] ? ipsvm_pkg::SECTOR_V5V6 : ipsvm_pkg::SECTOR_V6V1;
            end
            else
            begin
                sec_w = s6_diff_reg[QW-1] ? ipsvm_pkg::SECTOR_V4V5 : ipsvm_pkg::SECTOR_V5V6;
            end
        end
    end

    always_comb
    begin
        case (sec_w)
            ipsvm_pkg::SECTOR_V1V2:
            begin
                x_w = s6_diff_reg;
                y_w = s6_y0_reg;
            end
            ipsvm_pkg::SECTOR_V2V3:
            begin
                x_w = s6_sum_reg;
                y_w = -s6_diff_reg;
            end
            ipsvm_pkg::SECTOR_V3V4:
            begin
                x_w = -s6_sum_reg;
                y_w = s6_y0_reg;
            end
            ipsvm_pkg::SECTOR_V4V5:
            begin
                x_w = -s6_diff_reg;
                y_w = -s6_y0_reg;
            end
            ipsvm_pkg::SECTOR_V5V6:
            begin
                x_w = -s6_sum_reg;
                y_w = s6_diff_reg;
            end
            ipsvm_pkg::SECTOR_V6V1:
            begin
                x_w = s6_sum_reg;
                y_w = -s6_y0_reg;
            end
            default:
            begin
                x_w = s6_diff_reg;
                y_w = s6_y0_reg;
            end
        endcase
    end

    ipsvm_pkg::sector_t   s7_sector_reg;
    logic signed [QW-1:0] s7_x_reg;
    logic signed [QW-1:0] s7_y_reg;

    // Stage 8: the four candidate timings, each twice its value.
    ipsvm_pkg::sector_t   s8_sector_reg;
    logic signed [QW-1:0] s8_mm_reg;
    logic signed [QW-1:0] s8_pm_reg;
    logic signed [QW-1:0] s8_mp_reg;
    logic signed [QW-1:0] s8_pp_reg;

    // Stage 9: phase assignment, saturation and rounding.
    logic signed [QW-1:0] ta_w;
    logic signed [QW-1:0] tb_w;
    logic signed [QW-1:0] tc_w;

    always_comb
    begin
        case (s8_sector_reg)
            ipsvm_pkg::SECTOR_V1V2:
            begin
                ta_w = s8_mm_reg;
                tb_w = s8_pm_reg;
                tc_w = s8_pp_reg;
            end
            ipsvm_pkg::SECTOR_V2V3:
            begin
                ta_w = s8_mp_reg;
                tb_w = s8_mm_reg;
                tc_w = s8_pp_reg;
            end
            ipsvm_pkg::SECTOR_V3V4:
            begin
                ta_w = s8_pp_reg;
                tb_w = s8_mm_reg;
                tc_w = s8_mp_reg;
            end
            ipsvm_pkg::SECTOR_V4V5:
            begin
                ta_w = s8_pp_reg;
                tb_w = s8_mp_reg;
                tc_w = s8_mm_reg;
            end
            ipsvm_pkg::SECTOR_V5V6:
            begin
                ta_w = s8_pm_reg;
                tb_w = s8_pp_reg;
                tc_w = s8_mm_reg;
            end
            ipsvm_pkg::SECTOR_V6V1:
            begin
                ta_w = s8_mm_reg;
                tb_w = s8_pp_reg;
                tc_w = s8_pm_reg;
            end
            default:
            begin
                ta_w = s8_mm_reg;
                tb_w = s8_pm_reg;
                tc_w = s8_pp_reg;
            end
        endcase
    end

    logic [ipsvm_pkg::DUTY_W-1:0] duty_a_reg;
    logic [ipsvm_pkg::DUTY_W-1:0] duty_b_reg;
    logic [ipsvm_pkg::DUTY_W-1:0] duty_c_reg;
    logic [2:0]                   sector_reg;
    logic                         in_range_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_d_reg    <= volt_d;
            s1_q_reg    <= volt_q;
            s1_quad_reg <= rotor_angle[ANGLE_BITS-1 -: 2];
            s1_idx_reg  <= idx_w;
            s1_cidx_reg <= cidx_w;
        end
        if (adv[2])
        begin
            s2_d_reg    <= s1_d_reg;
            s2_q_reg    <= s1_q_reg;
            s2_quad_reg <= s1_quad_reg;
        end
        if (adv[3])
        begin
            s3_dc_reg    <= dc_full[ipsvm_pkg::PROD_W-1:0];
            s3_qs_reg    <= qs_full[ipsvm_pkg::PROD_W-1:0];
            s3_ds_reg    <= ds_full[ipsvm_pkg::PROD_W-1:0];
            s3_qc_reg    <= qc_full[ipsvm_pkg::PROD_W-1:0];
            s3_neg_s_reg <= s2_quad_reg[1];
            s3_neg_c_reg <= s2_quad_reg[1] ^ s2_quad_reg[0];
        end
        if (adv[4])
        begin
            s4_al_reg <= al_next;
            s4_be_reg <= be_next;
        end
        if (adv[5])
        begin
            s5_al_reg <= al50_w;
            s5_kb_reg <= QW'(kb_full);
            s5_y0_reg <= QW'(y0_full);
        end
        if (adv[6])
        begin
            s6_diff_reg   <= s5_al_reg - s5_kb_reg;
            s6_sum_reg    <= s5_al_reg + s5_kb_reg;
            s6_y0_reg     <= s5_y0_reg;
            s6_al_neg_reg <= s5_al_reg[QW-1];
            s6_be_neg_reg <= s5_kb_reg[QW-1];
        end
        if (adv[7])
        begin
            s7_sector_reg <= sec_w;
            s7_x_reg      <= x_w;
            s7_y_reg      <= y_w;
        end
        if (adv[8])
        begin
            s8_sector_reg <= s7_sector_reg;
            s8_mm_reg     <= ipsvm_pkg::Q50_ONE - s7_x_reg - s7_y_reg;
            s8_pm_reg     <= ipsvm_pkg::Q50_ONE + s7_x_reg - s7_y_reg;
            s8_mp_reg     <= ipsvm_pkg::Q50_ONE - s7_x_reg + s7_y_reg;
            s8_pp_reg     <= ipsvm_pkg::Q50_ONE + s7_x_reg + s7_y_reg;
        end
        if (adv[9])
        begin
            duty_a_reg   <= to_duty(ta_w);
            duty_b_reg   <= to_duty(tb_w);
            duty_c_reg   <= to_duty(tc_w);
            sector_reg   <= s8_sector_reg;
            in_range_reg <= within_unit(ta_w) && within_unit(tb_w) && within_unit(tc_w);
        end
    end

    assign duty_a   = duty_a_reg;
    assign duty_b   = duty_b_reg;
    assign duty_c   = duty_c_reg;
    assign sector   = sector_reg;
    assign in_range = in_range_reg;

endmodule
`default_nettype wire

### design/ipsvm_sine_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipsvm_sine_rom: quarter-wave sine table with two registered read ports
// Entry k holds sin(pi/2 * k / depth) in Q1.15. The contents are computed at
// elaboration from a fixed-point Taylor series.
// ----------------------------------------------------------------------------
module ipsvm_sine_rom #(
    parameter int SINE_TABLE_DEPTH = 1024,
    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  logic                            clk,
    input  logic                            rd_en,
    input  logic [ADDR_W-1:0]               addr_a,
    input  logic [ADDR_W-1:0]               addr_b,
    output logic [ipsvm_pkg::TAB_W-1:0]     data_a,
    output logic [ipsvm_pkg::TAB_W-1:0]     data_b
);

    localparam logic [63:0] DEPTH_L    = 64'(SINE_TABLE_DEPTH);
    localparam logic [63:0] HALF_DEPTH = 64'(SINE_TABLE_DEPTH / 2);

    function automatic logic [ipsvm_pkg::TAB_W-1:0] sine_entry(input int unsigned k);
        logic [63:0]        th;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        r;
        th = (64'(k) * ipsvm_pkg::HALF_PI_Q30 + HALF_DEPTH) / DEPTH_L;
        term = th;
        sum  = $signed(th);
        for (int n = 1; n <= ipsvm_pkg::TAYLOR_TERMS; n++)
        begin
            term = (((term * th) >> 30) * th) >> 30;
            case (n)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                5:       term = term / 64'd110;
                6:       term = term / 64'd156;
                7:       term = term / 64'd210;
                8:       term = term / 64'd272;
                9:       term = term / 64'd342;
                10:      term = term / 64'd420;
                11:      term = term / 64'd506;
                default: term = term / 64'd600;
            endcase
            if ((n & 1) == 1)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = '0;
        end
        r = ($unsigned(sum) + 64'd16384) >> 15;
        if (r > 64'd32768)
        begin
            r = 64'd32768;
        end
        return r[ipsvm_pkg::TAB_W-1:0];
    endfunction

    logic [ipsvm_pkg::TAB_W-1:0] sine_w [SINE_TABLE_DEPTH+1];
    logic [ipsvm_pkg::TAB_W-1:0] rd_a_reg;
    logic [ipsvm_pkg::TAB_W-1:0] rd_b_reg;

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_entry
        localparam logic [ipsvm_pkg::TAB_W-1:0] ENTRY = sine_entry(k);
        assign sine_w[k] = ENTRY;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_a_reg <= sine_w[addr_a];
            rd_b_reg <= sine_w[addr_b];
        end
    end

    assign data_a = rd_a_reg;
    assign data_b = rd_b_reg;

endmodule
`default_nettype wire
